[rtl/kde_pkg.sv]
// Shared key codes, event codes and divide-by-ten constants for keypad decimal entry.
package kde_pkg;

  localparam int unsigned AccumW = 30;
  localparam int unsigned CountW = 4;
  localparam int unsigned KeyW   = 8;
  localparam int unsigned CfgW   = 4;

  localparam logic [KeyW-1:0] KEY_FINISH = 8'h23;
  localparam logic [KeyW-1:0] KEY_ERASE  = 8'h43;
  localparam logic [KeyW-1:0] KEY_ZERO   = 8'h30;
  localparam logic [KeyW-1:0] KEY_NINE   = 8'h39;
  localparam logic [KeyW-1:0] KEY_STAR   = 8'h2A;

  localparam logic [CountW-1:0] DIGIT_CAP = 4'd9;

  // floor(n / 10) == (n * DIV10_MUL) >> DIV10_SHIFT for any n below 2^32
  localparam logic [31:0] DIV10_MUL   = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

  typedef enum logic [1:0] {
    EV_IGNORED = 2'd0,
    EV_DIGIT   = 2'd1,
    EV_ERASE   = 2'd2,
    EV_FINISH  = 2'd3
  } event_t;

  typedef enum logic {
    CFG_PIN_MODE   = 1'b0,
    CFG_MAX_DIGITS = 1'b1
  } cfg_idx_t;

endpackage

[rtl/keypad_decimal_entry.sv]
// Keypad decimal entry: folds ASCII key words into a decimal number, one result per key.
//
// Usage:
//   Input channel (in_valid / in_stall / in_key_code) carries one ASCII key per word.
//   Result channel (out_valid / out_stall / out_*) returns one word per key: the
//   event, the value held, the digit count and the echo character.
//   Configuration (cfg_we / cfg_index / cfg_data) sets PIN mode and the digit limit;
//   write it only while no key is in flight.
// Pipeline: an accepted key enters the input register, then its result moves into the
//   result register, which drives out_valid. Throughput: one key per cycle while out_stall
//   does not hold a full result register; the accumulator update
//   (times ten plus digit, or divide by ten through a reciprocal multiply) is
//   done combinationally between the two registers.
// Reset: value and digit count clear, PIN mode off, digit limit nine, both
//   pipeline registers empty.
// Stall: while out_stall holds a full result register, the input register can
//   still fill; once both are full, in_stall rises in the same cycle.
module keypad_decimal_entry
  import kde_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CfgW-1:0]   cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KeyW-1:0]   in_key_code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_event_res,
  output logic [AccumW-1:0] out_number_value,
  output logic [CountW-1:0] out_digit_count,
  output logic [KeyW-1:0]   out_echo_char
);

  logic              pin_mode_r;
  logic [CountW-1:0] max_digits_r;
  logic [AccumW-1:0] accum_r, accum_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              s1_vld_r;
  logic [KeyW-1:0]   s1_key_r;
  logic              out_vld_r;
  event_t            ev_nxt;
  logic [AccumW-1:0] value_nxt;
  logic [KeyW-1:0]   echo_nxt;
  logic [1:0]        out_ev_r;
  logic [AccumW-1:0] out_val_r;
  logic [CountW-1:0] out_cnt_r;
  logic [KeyW-1:0]   out_echo_r;
  logic              adv;
  logic [CountW-1:0] limit;
  logic              is_digit;
  logic [61:0]       div_prod;
  logic [AccumW-1:0] accum_div10;
  logic [AccumW-1:0] accum_app;

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !adv;

  assign limit     = (max_digits_r > DIGIT_CAP) ? DIGIT_CAP : max_digits_r;
  assign is_digit  = (s1_key_r >= KEY_ZERO) && (s1_key_r <= KEY_NINE);
  assign div_prod  = 62'(accum_r) * 62'(DIV10_MUL);
  assign accum_div10 = AccumW'(div_prod[61:DIV10_SHIFT]);
  // times ten as shift-and-add; the low nibble of an ASCII digit is its value
  assign accum_app = AccumW'({accum_r, 3'b000}) + AccumW'({accum_r, 1'b0})
                   + AccumW'(s1_key_r[3:0]);

  always_comb begin
    accum_nxt = accum_r;
    count_nxt = count_r;
    ev_nxt    = EV_IGNORED;
    echo_nxt  = '0;
    value_nxt = accum_r;
    priority if (is_digit) begin
      if (count_r < limit) begin
        accum_nxt = accum_app;
        count_nxt = count_r + 1'b1;
        ev_nxt    = EV_DIGIT;
        echo_nxt  = pin_mode_r ? KEY_STAR : s1_key_r;
      end
      value_nxt = accum_nxt;
    end else if (s1_key_r == KEY_ERASE) begin
      if (count_r != '0) begin
        accum_nxt = accum_div10;
        count_nxt = count_r - 1'b1;
        ev_nxt    = EV_ERASE;
      end
      value_nxt = accum_nxt;
    end else if (s1_key_r == KEY_FINISH) begin
      accum_nxt = '0;
      count_nxt = '0;
      ev_nxt    = EV_FINISH;
    end else begin
      value_nxt = accum_r;
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_mode_r   <= 1'b0;
      max_digits_r <= DIGIT_CAP;
      accum_r      <= '0;
      count_r      <= '0;
      s1_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PIN_MODE:   pin_mode_r   <= cfg_data[0];
          CFG_MAX_DIGITS: max_digits_r <= cfg_data;
          default:        ;
        endcase
      end
      if (!in_stall) begin
        s1_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= s1_vld_r;
      end
      if (adv && s1_vld_r) begin
        accum_r <= accum_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_key_r <= in_key_code;
    end
    if (adv && s1_vld_r) begin
      out_ev_r   <= ev_nxt;
      out_val_r  <= value_nxt;
      out_cnt_r  <= count_nxt;
      out_echo_r <= echo_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_event_res    = out_ev_r;
  assign out_number_value = out_val_r;
  assign out_digit_count  = out_cnt_r;
  assign out_echo_char    = out_echo_r;

endmodule

[rtl/kde_checker.sv]
// Port-level checks for keypad decimal entry, bound to the top level.
module kde_checker
  import kde_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        out_event_res,
  input logic [AccumW-1:0] out_number_value,
  input logic [CountW-1:0] out_digit_count,
  input logic [KeyW-1:0]   out_echo_char
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_res)
      && $stable(out_number_value) && $stable(out_digit_count) && $stable(out_echo_char))
    else $error("result word changed while stalled");

  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res == EV_FINISH) |-> (out_digit_count == '0))
    else $error("finish left digits held");

  a_echo_only_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res != EV_DIGIT) |-> (out_echo_char == '0))
    else $error("echo on a non-digit event");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_count <= DIGIT_CAP))
    else $error("digit count above cap");

endmodule

bind keypad_decimal_entry kde_checker u_kde_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_event_res    (out_event_res),
  .out_number_value (out_number_value),
  .out_digit_count  (out_digit_count),
  .out_echo_char    (out_echo_char)
);

[test/keypad_decimal_entry_test.sv]
// Self-checking testbench for the keypad decimal entry block, with randomized handshakes.
module keypad_decimal_entry_test;
  import kde_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Radix      = 10;
  localparam int unsigned Settle     = 6;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Phases     = 10;
  localparam int unsigned PhaseKeys  = 85;

  typedef struct packed {
    event_t              ev;
    logic [AccumW-1:0]   value;
    logic [CountW-1:0]   digits;
    logic [KeyW-1:0]     echo;
  } key_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  cfg_idx_t          cfg_index = CFG_PIN_MODE;
  logic [CfgW-1:0]   cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [KeyW-1:0]   in_key_code = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_event_res;
  logic [AccumW-1:0] out_number_value;
  logic [CountW-1:0] out_digit_count;
  logic [KeyW-1:0]   out_echo_char;

  // predictor state
  logic              pin_q = 1'b0;
  logic [CfgW-1:0]   limit_q = 4'd9;
  logic [AccumW-1:0] value_q = '0;
  logic [CountW-1:0] held_q = '0;

  key_result_t pending_results[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned keys_sent = 0;
  int unsigned settings = 0;
  int unsigned events_seen[4] = '{0, 0, 0, 0};
  bit          calm = 1'b0;
  int unsigned stall_left = 0;

  keypad_decimal_entry dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_code      (in_key_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_number_value (out_number_value),
    .out_digit_count  (out_digit_count),
    .out_echo_char    (out_echo_char)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("keypad_decimal_entry_test: done, errors");
      $finish;
    end
  end

  // mostly short gaps, a few long ones, none while calm
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // fold one key into the predicted entry state and return its result word
  function automatic key_result_t fold_key(logic [KeyW-1:0] k);
    key_result_t     r;
    logic [CfgW-1:0] lim;
    lim = (limit_q > DIGIT_CAP) ? DIGIT_CAP : limit_q;
    r.ev = EV_IGNORED;
    r.echo = '0;
    if (k >= KEY_ZERO && k <= KEY_NINE) begin
      if (held_q < lim) begin
        value_q = AccumW'(value_q * Radix + (k - KEY_ZERO));
        held_q = held_q + 1'b1;
        r.ev = EV_DIGIT;
        r.echo = pin_q ? KEY_STAR : k;
      end
      r.value = value_q;
    end else if (k == KEY_ERASE) begin
      if (held_q != 0) begin
        value_q = value_q / Radix;
        held_q = held_q - 1'b1;
        r.ev = EV_ERASE;
      end
      r.value = value_q;
    end else if (k == KEY_FINISH) begin
      r.value = value_q;
      value_q = '0;
      held_q = '0;
      r.ev = EV_FINISH;
    end else begin
      r.value = value_q;
    end
    r.digits = held_q;
    return r;
  endfunction

  // compare accepted result words against the oldest prediction; drive out_stall
  always @(posedge clk) begin
    key_result_t want;
    int unsigned gap;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: event %0d value %0d",
               out_event_res, out_number_value);
        errors++;
      end else begin
        want = pending_results.pop_front();
        events_seen[out_event_res]++;
        if (out_event_res !== want.ev) begin
          $error("event_res: expected %0d, got %0d", want.ev, out_event_res);
          errors++;
        end
        if (out_number_value !== want.value) begin
          $error("number_value: expected %0d, got %0d", want.value, out_number_value);
          errors++;
        end
        if (out_digit_count !== want.digits) begin
          $error("digit_count: expected %0d, got %0d", want.digits, out_digit_count);
          errors++;
        end
        if (out_echo_char !== want.echo) begin
          $error("echo_char: expected %0h, got %0h", want.echo, out_echo_char);
          errors++;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      gap = pick_gap();
      out_stall <= (gap > 0);
      stall_left = (gap > 0) ? gap - 1 : 0;
    end
  end

  // send one key word; returns at the edge where it was accepted
  task automatic press_key(input logic [KeyW-1:0] k);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_code <= k;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(fold_key(k));
    keys_sent++;
  endtask

  // drop valid and wait until every predicted word has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_PIN_MODE) pin_q = data[0];
    else limit_q = data;
  endtask

  task automatic set_mode(input logic pin, input logic [CfgW-1:0] limit);
    settle();
    write_reg(CFG_PIN_MODE, {CfgW'($urandom_range(0, 7)) << 1} | CfgW'(pin));
    write_reg(CFG_MAX_DIGITS, limit);
    settings++;
  endtask

  // reset limit of nine: fill to the limit, one digit past it, finish at the top value
  task automatic test_default_limit();
    repeat (9) press_key(KEY_NINE);
    press_key(KEY_ZERO);
    press_key(KEY_FINISH);
  endtask

  // erase and finish on an empty entry, then keys just outside the digit range and codes 00 and FF
  task automatic test_empty_and_stray_keys();
    press_key(KEY_ERASE);
    press_key(KEY_FINISH);
    press_key(KEY_ZERO - 1'b1);
    press_key(KEY_NINE + 1'b1);
    press_key(8'h00);
    press_key(8'hFF);
  endtask

  // star echo, digit at a small limit, then limit lowered below the digits held
  task automatic test_pin_and_lowered_limit();
    set_mode(1'b1, 4'd2);
    press_key(KEY_ZERO + 8'd3);
    press_key(KEY_ZERO + 8'd4);
    press_key(KEY_ZERO + 8'd5);
    set_mode(1'b1, 4'd1);
    press_key(KEY_ZERO + 8'd6);
    press_key(KEY_ERASE);
    press_key(KEY_FINISH);
    set_mode(1'b0, 4'd0);
    press_key(KEY_ZERO);
  endtask

  function automatic logic [KeyW-1:0] next_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return KEY_ZERO + KeyW'($urandom_range(0, 9));
    if (r < 80) return KEY_ERASE;
    if (r < 86) return KEY_FINISH;
    return KeyW'($urandom_range(0, 255));
  endfunction

  // random entries under a series of register settings, extremes first
  task automatic test_random_entries();
    logic [CfgW-1:0] limits[6] = '{4'd9, 4'd1, 4'd15, 4'd0, 4'd4, 4'd9};
    logic [CfgW-1:0] limit;
    for (int p = 0; p < Phases; p++) begin
      limit = (p < 6) ? limits[p] : CfgW'($urandom_range(0, 15));
      set_mode(p[0], limit);
      calm = (p % 4 == 2);
      repeat (PhaseKeys) press_key(next_key());
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_limit();
    test_empty_and_stray_keys();
    test_pin_and_lowered_limit();
    test_random_entries();
    settle();
    $display("ran %0d keys under %0d register settings in %0d cycles", keys_sent,
             settings, cycles);
    $display("results: %0d ignored, %0d digits, %0d erasures, %0d finishes",
             events_seen[EV_IGNORED], events_seen[EV_DIGIT], events_seen[EV_ERASE],
             events_seen[EV_FINISH]);
    if (errors == 0) begin
      $display("keypad_decimal_entry_test: done, clean");
    end else begin
      $display("keypad_decimal_entry_test: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/kde_pkg.sv
rtl/keypad_decimal_entry.sv
rtl/kde_checker.sv
test/keypad_decimal_entry_test.sv
